[rtl/core/cqar_pkg.sv]
// Package for the stop-and-wait command queue.
// Holds the item structs, the controller/datapath command and status structs,
// and the request, event, status and register codes. No dependencies.
package cqar_pkg;

  localparam int unsigned TMR_W = 17;
  localparam int unsigned ATT_W = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [1:0] REQ_ENQ  = 2'd0;
  localparam logic [1:0] REQ_RSP  = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam logic [2:0] KIND_TX       = 3'd0;
  localparam logic [2:0] KIND_QUERY    = 3'd1;
  localparam logic [2:0] KIND_DONE     = 3'd2;
  localparam logic [2:0] KIND_ERRREPLY = 3'd3;
  localparam logic [2:0] KIND_CONNERR  = 3'd4;
  localparam logic [2:0] KIND_REJECT   = 3'd5;

  localparam logic [7:0] STATUS_ACK = 8'h33;
  localparam logic [7:0] STATUS_ERR = 8'h55;
  localparam logic [7:0] CMD_FOLLOW = 8'h24;
  localparam logic [7:0] QUERY_DEV  = 8'h02;
  localparam logic [7:0] QUERY_CMD  = 8'h76;
  localparam logic [7:0] CTRL_DEV   = 8'h01;

  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATT  = 2'd2;

  localparam logic [TMR_W-1:0] SHORT_TO_RST = 17'd2000;
  localparam logic [TMR_W-1:0] LONG_TO_RST  = 17'd120000;
  localparam logic [ATT_W-1:0] MAX_ATT_RST  = 3'd3;
  localparam logic [ATT_W-1:0] ATT_SAT      = 3'd7;

  localparam logic [1:0] SRC_INPUT = 2'd0;
  localparam logic [1:0] SRC_HEAD  = 2'd1;
  localparam logic [1:0] SRC_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  dev_id;
    logic [7:0]  cmd_code;
    logic [7:0]  status_code;
    logic [15:0] payload_tag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic        to_ctrl_port;
    logic [7:0]  out_dev_id;
    logic [7:0]  out_cmd_code;
    logic [15:0] out_tag;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic       latch_in;
    logic       enq_write;
    logic       retire;
    logic       set_long;
    logic       tick_dec;
    logic       timeout;
    logic       flush;
    logic       tx_start;
    logic       tx_clr_tc;
    logic       out_load;
    logic [2:0] out_kind;
    logic [1:0] out_src;
    logic       out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       full;
    logic       cnt_nz;
    logic       cnt_gt1;
    logic       awaiting;
    logic       head_match;
    logic       is_ack;
    logic       is_err;
    logic       cmd_follow;
    logic       timer_le1;
    logic       tc_under_max;
    logic       out_free;
  } dp_sts_t;

endpackage

[rtl/core/cqar_dp.sv]
// Datapath of the command queue: pending store, ring pointers, wait timer,
// retry count, configuration registers and the output register.
// Depends on cqar_pkg; driven by cqar_ctrl through dp_cmd_t.
module cqar_dp #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cqar_pkg::in_item_t            in_item_i,
  input  logic                          cfg_we_i,
  input  logic [cqar_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cqar_pkg::TMR_W-1:0]    cfg_wdata_i,
  input  cqar_pkg::dp_cmd_t             cmd_i,
  output cqar_pkg::dp_sts_t             sts_o,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output cqar_pkg::out_item_t           out_item_o
);
  import cqar_pkg::*;

  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [31:0]      mem [QUEUE_DEPTH];
  logic [31:0]      rd_q;
  in_item_t         in_q;
  logic [IDX_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             await_q, await_d;
  logic [ATT_W-1:0] tc_q, tc_d, tc_inc;
  logic [TMR_W-1:0] timer_q, timer_d;
  logic [TMR_W-1:0] short_q, long_q;
  logic [ATT_W-1:0] max_q;
  logic             out_valid_q;
  out_item_t        out_q;
  logic [7:0]       sel_dev, sel_cmd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.enq_write) begin
      mem[tail_q] <= {in_q.dev_id, in_q.cmd_code, in_q.payload_tag};
    end
    rd_q <= mem[head_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      in_q <= in_item_i;
    end
  end

  assign tc_inc = (tc_q == ATT_SAT) ? ATT_SAT : tc_q + 1'b1;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    cnt_d   = cnt_q;
    await_d = await_q;
    tc_d    = tc_q;
    timer_d = timer_q;
    if (cmd_i.enq_write) begin
      tail_d = (tail_q == IDX_LAST) ? '0 : tail_q + 1'b1;
      cnt_d  = cnt_q + 1'b1;
    end
    if (cmd_i.set_long) begin
      timer_d = long_q;
    end
    if (cmd_i.tick_dec) begin
      timer_d = timer_q - 1'b1;
    end
    if (cmd_i.retire) begin
      head_d  = (head_q == IDX_LAST) ? '0 : head_q + 1'b1;
      cnt_d   = cnt_q - 1'b1;
      await_d = 1'b0;
      timer_d = '0;
    end
    if (cmd_i.timeout) begin
      tc_d    = tc_inc;
      await_d = 1'b0;
      timer_d = '0;
    end
    if (cmd_i.flush) begin
      head_d  = '0;
      tail_d  = '0;
      cnt_d   = '0;
      await_d = 1'b0;
      timer_d = '0;
    end
    if (cmd_i.tx_start) begin
      await_d = 1'b1;
      timer_d = short_q;
      if (cmd_i.tx_clr_tc) begin
        tc_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      await_q <= 1'b0;
      tc_q    <= '0;
      timer_q <= '0;
      short_q <= SHORT_TO_RST;
      long_q  <= LONG_TO_RST;
      max_q   <= MAX_ATT_RST;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      await_q <= await_d;
      tc_q    <= tc_d;
      timer_q <= timer_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SHORT_TO: short_q <= cfg_wdata_i;
          CFG_LONG_TO:  long_q  <= cfg_wdata_i;
          CFG_MAX_ATT:  max_q   <= cfg_wdata_i[ATT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    sts_o.req_type     = in_q.req_type;
    sts_o.full         = (cnt_q >= CNT_FULL);
    sts_o.cnt_nz       = (cnt_q != '0);
    sts_o.cnt_gt1      = (cnt_q > CNT_W'(1));
    sts_o.awaiting     = await_q;
    sts_o.head_match   = await_q && (cnt_q != '0) && (rd_q[31:24] == in_q.dev_id)
                         && (rd_q[23:16] == in_q.cmd_code);
    sts_o.is_ack       = (in_q.status_code == STATUS_ACK);
    sts_o.is_err       = (in_q.status_code == STATUS_ERR);
    sts_o.cmd_follow   = (in_q.cmd_code == CMD_FOLLOW);
    sts_o.timer_le1    = (timer_q <= TMR_W'(1));
    sts_o.tc_under_max = (tc_inc < max_q);
    sts_o.out_free     = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    case (cmd_i.out_src)
      SRC_HEAD: begin
        sel_dev = rd_q[31:24];
        sel_cmd = rd_q[23:16];
      end
      SRC_QUERY: begin
        sel_dev = QUERY_DEV;
        sel_cmd = QUERY_CMD;
      end
      default: begin
        sel_dev = in_q.dev_id;
        sel_cmd = in_q.cmd_code;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.event_kind   <= cmd_i.out_kind;
      out_q.to_ctrl_port <= (sel_dev == CTRL_DEV);
      out_q.out_dev_id   <= sel_dev;
      out_q.out_cmd_code <= sel_cmd;
      out_q.out_tag      <= (cmd_i.out_kind == KIND_TX) ? rd_q[15:0] : 16'd0;
      out_q.last_result  <= cmd_i.out_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[rtl/core/cqar_ctrl.sv]
// Controller of the command queue: sequences accept, evaluation and the
// results of one item. Depends on cqar_pkg; commands cqar_dp via dp_cmd_t.
module cqar_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cqar_pkg::dp_sts_t sts_i,
  output cqar_pkg::dp_cmd_t cmd_o
);
  import cqar_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EVAL  = 4'd1;
  localparam logic [3:0] S_QUERY = 4'd2;
  localparam logic [3:0] S_DONE  = 4'd3;
  localparam logic [3:0] S_ERR   = 4'd4;
  localparam logic [3:0] S_REJ   = 4'd5;
  localparam logic [3:0] S_CONN  = 4'd6;
  localparam logic [3:0] S_SYNC  = 4'd7;
  localparam logic [3:0] S_TX    = 4'd8;

  logic [3:0] state_q, state_d;
  logic       tx_pend_q, tx_pend_d;
  logic       tx_clr_q, tx_clr_d;
  logic       match;

  assign match      = sts_i.head_match;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    tx_pend_d = tx_pend_q;
    tx_clr_d  = tx_clr_q;
    cmd_o     = '0;
    cmd_o.out_src = SRC_INPUT;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = S_IDLE;
        case (sts_i.req_type)
          REQ_ENQ: begin
            if (sts_i.full) begin
              state_d = S_REJ;
            end else begin
              cmd_o.enq_write = 1'b1;
              if (!sts_i.awaiting) begin
                tx_clr_d = 1'b1;
                state_d  = S_SYNC;
              end
            end
          end
          REQ_RSP: begin
            if (sts_i.is_ack) begin
              cmd_o.retire = match;
              tx_pend_d    = !(sts_i.awaiting && !match)
                             && (match ? sts_i.cnt_gt1 : sts_i.cnt_nz);
              tx_clr_d     = 1'b1;
              state_d      = (match && sts_i.cmd_follow) ? S_QUERY : S_DONE;
            end else if (sts_i.is_err) begin
              cmd_o.retire = match;
              state_d      = S_ERR;
            end else begin
              cmd_o.set_long = match;
            end
          end
          REQ_TICK: begin
            if (sts_i.awaiting) begin
              if (sts_i.timer_le1) begin
                cmd_o.timeout = 1'b1;
                if (sts_i.tc_under_max) begin
                  tx_clr_d = 1'b0;
                  state_d  = S_SYNC;
                end else if (sts_i.cnt_nz) begin
                  state_d = S_CONN;
                end
              end else begin
                cmd_o.tick_dec = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      S_QUERY: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KIND_QUERY;
          cmd_o.out_src  = SRC_QUERY;
          state_d        = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KIND_DONE;
          cmd_o.out_last = !tx_pend_q;
          state_d        = tx_pend_q ? S_SYNC : S_IDLE;
        end
      end
      S_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KIND_ERRREPLY;
          cmd_o.out_last = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_REJ: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KIND_REJECT;
          cmd_o.out_last = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_CONN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KIND_CONNERR;
          cmd_o.out_src  = SRC_HEAD;
          cmd_o.out_last = 1'b1;
          cmd_o.flush    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_SYNC: begin
        // head entry read settles after a pointer move or store write
        state_d = S_TX;
      end
      S_TX: begin
        if (sts_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_kind  = KIND_TX;
          cmd_o.out_src   = SRC_HEAD;
          cmd_o.out_last  = 1'b1;
          cmd_o.tx_start  = 1'b1;
          cmd_o.tx_clr_tc = tx_clr_q;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      tx_pend_q <= 1'b0;
      tx_clr_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      tx_pend_q <= tx_pend_d;
      tx_clr_q  <= tx_clr_d;
    end
  end

endmodule

[rtl/core/command_queue_ack_retry.sv]
// Top level of the stop-and-wait command queue with acknowledge and retry.
// Joins cqar_ctrl and cqar_dp; types and codes from cqar_pkg.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   cqar_pkg::in_item_t
//   out      output     out_valid_o / out_stall_i cqar_pkg::out_item_t
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// An item is accepted, then evaluated, then each result is loaded into the output
// register; before a transmit, a sync state waits for the registered head read
// of the store. There is one registered store read port and one output register.
// The store is not cleared at reset; only entries once written are read.
// A stalled output holds the sequencer in a result state; no item is taken then.
module command_queue_ack_retry #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  cqar_pkg::in_item_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output cqar_pkg::out_item_t            out_item_o,
  input  logic                           cfg_we_i,
  input  logic [cqar_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cqar_pkg::TMR_W-1:0]     cfg_wdata_i
);
  import cqar_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  cqar_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cqar_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

[rtl/core/cqar_checker.sv]
// Port-level checks for command_queue_ack_retry, attached by bind.
// Depends on cqar_pkg.
module cqar_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input cqar_pkg::out_item_t out_item_o
);
  import cqar_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  a_port_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.to_ctrl_port == (out_item_o.out_dev_id == CTRL_DEV))
    else $error("port select does not follow device id");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.event_kind <= KIND_REJECT)
    else $error("undefined event kind");

  a_tag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.event_kind != KIND_TX |-> out_item_o.out_tag == 16'd0)
    else $error("nonzero tag on a non-transmit result");

  a_query_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_item_o.event_kind == KIND_QUERY
    |-> !out_item_o.last_result && in_stall_o)
    else $error("follow-up query must be followed by finished");

endmodule

bind command_queue_ack_retry cqar_checker u_cqar_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

[verif/testbench.sv]
// Testbench for command_queue_ack_retry: a directed table, then random phases with
// fresh register settings; typed table rows are checked against their own events,
// the rest against a cycle-free model of the queue. Depends on cqar_pkg and the RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cqar_pkg::*;

  localparam int QDEPTH = 16;
  localparam int PREDICT = -1;
  localparam logic [1:0] REQ_UNDEF = 2'd3;

  typedef struct packed {
    logic [7:0]  dev;
    logic [7:0]  cmd;
    logic [15:0] tag;
  } cmd_entry_t;

  typedef struct packed {
    logic                is_cfg;
    logic [1:0]          reg_idx;
    logic [16:0]         reg_val;
    in_item_t            item;
    logic                typed_ok;
    logic [1:0]          n_typed;
    out_item_t [0:2]     typed;
  } row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_item_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_item_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [TMR_W-1:0]     cfg_wdata_i = '0;

  bit                   quiet = 1'b0;
  int                   mismatches = 0;

  // queue model state
  cmd_entry_t           pend [QDEPTH];
  int unsigned          q_head, q_tail, q_count;
  bit                   q_busy;
  logic [2:0]           q_tries;
  logic [16:0]          q_timer;
  logic [16:0]          short_to, long_to;
  logic [2:0]           max_att;
  out_item_t            step_events[$];
  out_item_t            expected_events[$];
  row_t                 plan[$];

  command_queue_ack_retry #(.QUEUE_DEPTH(QDEPTH)) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic note_mismatch(string msg);
    mismatches++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  function automatic in_item_t mk_item(logic [1:0] req, logic [7:0] dev, logic [7:0] cmd,
                                       logic [7:0] st, logic [15:0] tag);
    in_item_t it;
    it.req_type = req;
    it.dev_id = dev;
    it.cmd_code = cmd;
    it.status_code = st;
    it.payload_tag = tag;
    return it;
  endfunction

  function automatic out_item_t mk_event(logic [2:0] kind, logic [7:0] dev, logic [7:0] cmd,
                                         logic [15:0] tag, logic last);
    out_item_t ev;
    ev.event_kind = kind;
    ev.to_ctrl_port = (dev == CTRL_DEV);
    ev.out_dev_id = dev;
    ev.out_cmd_code = cmd;
    ev.out_tag = tag;
    ev.last_result = last;
    return ev;
  endfunction

  function automatic row_t item_row(in_item_t it, int n, out_item_t e0 = '0,
                                    out_item_t e1 = '0, out_item_t e2 = '0);
    row_t r;
    r = '0;
    r.item = it;
    r.typed_ok = (n >= 0);
    r.n_typed = (n >= 0) ? n[1:0] : 2'd0;
    r.typed = {e0, e1, e2};
    return r;
  endfunction

  function automatic row_t cfg_row(logic [1:0] idx, logic [16:0] val);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic void add_event(logic [2:0] kind, logic [7:0] dev, logic [7:0] cmd,
                                    logic [15:0] tag);
    step_events.push_back(mk_event(kind, dev, cmd, tag, 1'b0));
  endfunction

  function automatic void send_head(bit clear_tries);
    if (q_busy || q_count == 0) return;
    add_event(KIND_TX, pend[q_head].dev, pend[q_head].cmd, pend[q_head].tag);
    q_timer = short_to;
    q_busy = 1'b1;
    if (clear_tries) q_tries = '0;
  endfunction

  function automatic void retire_head();
    q_head = (q_head + 1) % QDEPTH;
    q_count--;
    q_busy = 1'b0;
    q_timer = '0;
  endfunction

  // Events one accepted transfer causes; advances the model state.
  function automatic void predict_events(in_item_t it);
    bit match;
    step_events.delete();
    match = q_busy && q_count != 0 && pend[q_head].dev == it.dev_id &&
            pend[q_head].cmd == it.cmd_code;
    case (it.req_type)
      REQ_ENQ: begin
        if (q_count >= QDEPTH) begin
          add_event(KIND_REJECT, it.dev_id, it.cmd_code, '0);
        end else begin
          pend[q_tail] = '{it.dev_id, it.cmd_code, it.payload_tag};
          q_tail = (q_tail + 1) % QDEPTH;
          q_count++;
          send_head(1'b1);
        end
      end
      REQ_RSP: begin
        if (match) q_timer = long_to;
        if (it.status_code == STATUS_ACK) begin
          if (match) begin
            retire_head();
            if (it.cmd_code == CMD_FOLLOW) add_event(KIND_QUERY, QUERY_DEV, QUERY_CMD, '0);
          end
          add_event(KIND_DONE, it.dev_id, it.cmd_code, '0);
          send_head(1'b1);
        end else if (it.status_code == STATUS_ERR) begin
          if (match) retire_head();
          add_event(KIND_ERRREPLY, it.dev_id, it.cmd_code, '0);
        end
      end
      REQ_TICK: begin
        if (q_busy) begin
          if (q_timer <= 17'd1) begin
            q_timer = '0;
            if (q_tries != ATT_SAT) q_tries++;
            q_busy = 1'b0;
            if (q_tries < max_att) begin
              send_head(1'b0);
            end else if (q_count != 0) begin
              add_event(KIND_CONNERR, pend[q_head].dev, pend[q_head].cmd, '0);
              q_head = 0;
              q_tail = 0;
              q_count = 0;
            end
          end else begin
            q_timer--;
          end
        end
      end
      default: ;
    endcase
    if (step_events.size() != 0) step_events[step_events.size() - 1].last_result = 1'b1;
  endfunction

  function automatic in_item_t random_item(int enq_w);
    in_item_t it;
    int unsigned r;
    it = mk_item(REQ_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
    r = $urandom_range(99);
    if (r < enq_w) begin
      it.req_type = REQ_ENQ;
      case ($urandom_range(2))
        0: it.dev_id = CTRL_DEV;
        1: it.dev_id = 8'($urandom_range(3));
        default: ;
      endcase
      if ($urandom_range(2) == 0) it.cmd_code = CMD_FOLLOW;
    end else if (r < enq_w + 35) begin
      it.req_type = REQ_RSP;
      if (q_count != 0 && $urandom_range(99) < 70) begin
        it.dev_id = pend[q_head].dev;
        it.cmd_code = pend[q_head].cmd;
      end
      r = $urandom_range(9);
      if (r < 4) it.status_code = STATUS_ACK;
      else if (r < 6) it.status_code = STATUS_ERR;
    end else if (r >= 97) begin
      it.req_type = REQ_UNDEF;
    end
    return it;
  endfunction

  // Starts and ends at a falling edge.
  task automatic drive_item(in_item_t it, logic typed_ok, logic [1:0] n_typed,
                            out_item_t [0:2] typed);
    int k;
    while (!quiet && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_events(it);
    if (typed_ok) begin
      for (k = 0; k < n_typed; k++) expected_events.push_back(typed[k]);
    end else begin
      for (k = 0; k < step_events.size(); k++) expected_events.push_back(step_events[k]);
    end
    @(negedge clk_i);
  endtask

  task automatic settle();
    int waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (expected_events.size() != 0 && waited < 5000) begin
      @(negedge clk_i);
      waited++;
    end
    if (expected_events.size() != 0) begin
      note_mismatch($sformatf("%0d expected events never came", expected_events.size()));
      expected_events.delete();
    end
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      CFG_SHORT_TO: short_to = val;
      CFG_LONG_TO:  long_to = val;
      CFG_MAX_ATT:  max_att = val[2:0];
      default: ;
    endcase
  endtask

  task automatic check_event(out_item_t got);
    out_item_t want;
    if (expected_events.size() == 0) begin
      note_mismatch($sformatf("unexpected event %h", got));
      return;
    end
    want = expected_events.pop_front();
    if (got.event_kind !== want.event_kind)
      note_mismatch($sformatf("event_kind %0d, want %0d", got.event_kind, want.event_kind));
    if (got.to_ctrl_port !== want.to_ctrl_port)
      note_mismatch($sformatf("to_ctrl_port %b, want %b", got.to_ctrl_port, want.to_ctrl_port));
    if (got.out_dev_id !== want.out_dev_id)
      note_mismatch($sformatf("out_dev_id %h, want %h", got.out_dev_id, want.out_dev_id));
    if (got.out_cmd_code !== want.out_cmd_code)
      note_mismatch($sformatf("out_cmd_code %h, want %h", got.out_cmd_code, want.out_cmd_code));
    if (got.out_tag !== want.out_tag)
      note_mismatch($sformatf("out_tag %h, want %h", got.out_tag, want.out_tag));
    if (got.last_result !== want.last_result)
      note_mismatch($sformatf("last_result %b, want %b", got.last_result, want.last_result));
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < 11);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) check_event(out_item_o);
  end

  initial begin
    int i;
    int p;
    int enq_w;
    int counted;
    in_item_t it;

    q_head = 0;
    q_tail = 0;
    q_count = 0;
    q_busy = 1'b0;
    q_tries = '0;
    q_timer = '0;
    short_to = SHORT_TO_RST;
    long_to = LONG_TO_RST;
    max_att = MAX_ATT_RST;

    // reset values: ack with follow-up, progress, error replies, idle tick, ack restart
    plan.push_back(item_row(mk_item(REQ_ENQ, CTRL_DEV, CMD_FOLLOW, 8'($urandom), 16'hFFFF), 1,
                            mk_event(KIND_TX, CTRL_DEV, CMD_FOLLOW, 16'hFFFF, 1'b1)));
    plan.push_back(item_row(mk_item(REQ_RSP, CTRL_DEV, CMD_FOLLOW, 8'h10, 16'($urandom)), 0));
    plan.push_back(item_row(mk_item(REQ_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                                    16'($urandom)), 0));
    plan.push_back(item_row(mk_item(REQ_RSP, CTRL_DEV, CMD_FOLLOW, STATUS_ACK, 16'($urandom)), 2,
                            mk_event(KIND_QUERY, QUERY_DEV, QUERY_CMD, '0, 1'b0),
                            mk_event(KIND_DONE, CTRL_DEV, CMD_FOLLOW, '0, 1'b1)));
    plan.push_back(item_row(mk_item(REQ_ENQ, 8'hFF, 8'hFF, 8'($urandom), 16'h0000), 1,
                            mk_event(KIND_TX, 8'hFF, 8'hFF, 16'h0000, 1'b1)));
    plan.push_back(item_row(mk_item(REQ_ENQ, 8'h00, 8'h00, 8'($urandom), 16'h1234), 0));
    plan.push_back(item_row(mk_item(REQ_RSP, 8'h07, 8'h09, STATUS_ERR, 16'($urandom)), 1,
                            mk_event(KIND_ERRREPLY, 8'h07, 8'h09, '0, 1'b1)));
    plan.push_back(item_row(mk_item(REQ_RSP, 8'hFF, 8'hFF, STATUS_ERR, 16'($urandom)), 1,
                            mk_event(KIND_ERRREPLY, 8'hFF, 8'hFF, '0, 1'b1)));
    plan.push_back(item_row(mk_item(REQ_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                                    16'($urandom)), 0));
    plan.push_back(item_row(mk_item(REQ_UNDEF, 8'($urandom), 8'($urandom), 8'($urandom),
                                    16'($urandom)), 0));
    plan.push_back(item_row(mk_item(REQ_RSP, 8'h03, 8'h04, STATUS_ACK, 16'($urandom)), 2,
                            mk_event(KIND_DONE, 8'h03, 8'h04, '0, 1'b0),
                            mk_event(KIND_TX, 8'h00, 8'h00, 16'h1234, 1'b1)));
    // zero timer, zero attempts, then fill the queue past full
    plan.push_back(cfg_row(CFG_SHORT_TO, 17'd0));
    plan.push_back(cfg_row(CFG_LONG_TO, 17'h1FFFF));
    plan.push_back(cfg_row(CFG_MAX_ATT, 17'd0));
    for (i = 1; i < QDEPTH; i++)
      plan.push_back(item_row(mk_item(REQ_ENQ, 8'(i), 8'(i * 17), 8'($urandom),
                                      16'(i * 4369)), 0));
    plan.push_back(item_row(mk_item(REQ_ENQ, CTRL_DEV, 8'hA5, 8'($urandom), 16'hBEEF), 1,
                            mk_event(KIND_REJECT, CTRL_DEV, 8'hA5, '0, 1'b1)));
    plan.push_back(item_row(mk_item(REQ_RSP, 8'h00, 8'h00, STATUS_ACK, 16'($urandom)), PREDICT));
    plan.push_back(item_row(mk_item(REQ_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                                    16'($urandom)), PREDICT));

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        settle();
        write_reg(plan[k].reg_idx, plan[k].reg_val);
      end else begin
        drive_item(plan[k].item, plan[k].typed_ok, plan[k].n_typed, plan[k].typed);
      end
    end

    for (p = 0; p < 10; p++) begin
      settle();
      write_reg(CFG_SHORT_TO, (p == 2) ? 17'h1FFFF : (p == 5) ? 17'd1 : (p == 8) ? 17'd0 :
                              17'($urandom_range(1, 4)));
      write_reg(CFG_LONG_TO, (p == 2 || p == 7) ? 17'h1FFFF : (p == 6) ? 17'd0 :
                             (p == 9) ? 17'd1 : 17'($urandom_range(2, 10)));
      write_reg(CFG_MAX_ATT, 17'(p % 8));
      quiet <= (p == 4);
      enq_w = (p == 2 || p == 7) ? 55 : 30;
      counted = 0;
      while (counted < 50) begin
        it = random_item(enq_w);
        counted++;
        drive_item(it, 1'b0, 2'd0, '0);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
